>>> hdl/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg: shared definitions for the cartridge bank mapper
// Operation codes, save-RAM unlock keys, register addresses and the
// structures that travel between the decode logic, the save RAM and the top.
// ----------------------------------------------------------------------------
package cbm_pkg;

    // Default sizes, handed to the top-level parameters.
    localparam int SAVE_RAM_DEPTH_DEF = 8192;
    localparam int PRG_BANK_BITS_DEF  = 6;
    localparam int CHR_BANK_BITS_DEF  = 8;

    // Fixed field widths.
    localparam int OP_W    = 2;
    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 8;
    localparam int PRG_W   = 19;
    localparam int CHR_W   = 18;
    localparam int RAM_IDX_W = 13;

    // Request kinds.
    localparam logic [OP_W-1:0] OP_CPU_READ  = 2'd0;
    localparam logic [OP_W-1:0] OP_CPU_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_PPU_FETCH = 2'd2;

    // Save-RAM unlock keys, one per region.
    localparam logic [DATA_W-1:0] KEY_REGION0 = 8'hCA;
    localparam logic [DATA_W-1:0] KEY_REGION1 = 8'h69;
    localparam logic [DATA_W-1:0] KEY_REGION2 = 8'h84;

    // Mapper register addresses.
    localparam logic [ADDR_W-1:0] REG_CHR0   = 16'h7EF0;
    localparam logic [ADDR_W-1:0] REG_CHR1   = 16'h7EF1;
    localparam logic [ADDR_W-1:0] REG_CHR2   = 16'h7EF2;
    localparam logic [ADDR_W-1:0] REG_CHR3   = 16'h7EF3;
    localparam logic [ADDR_W-1:0] REG_CHR4   = 16'h7EF4;
    localparam logic [ADDR_W-1:0] REG_CHR5   = 16'h7EF5;
    localparam logic [ADDR_W-1:0] REG_CTRL   = 16'h7EF6;
    localparam logic [ADDR_W-1:0] REG_KEY0   = 16'h7EF7;
    localparam logic [ADDR_W-1:0] REG_KEY1   = 16'h7EF8;
    localparam logic [ADDR_W-1:0] REG_KEY2   = 16'h7EF9;
    localparam logic [ADDR_W-1:0] REG_PRG0   = 16'h7EFA;
    localparam logic [ADDR_W-1:0] REG_PRG1   = 16'h7EFB;
    localparam logic [ADDR_W-1:0] REG_PRG2   = 16'h7EFC;

    // Save-RAM access command issued at request acceptance.
    typedef struct packed {
        logic                 rd;
        logic                 wr;
        logic [RAM_IDX_W-1:0] idx;
        logic [DATA_W-1:0]    wdata;
    } ram_cmd_t;

    // Result fields known at acceptance; RAM data joins after the registered save-RAM read.
    typedef struct packed {
        logic              from_ram;
        logic [DATA_W-1:0] bus_byte;
        logic [PRG_W-1:0]  prg_address;
        logic [CHR_W-1:0]  chr_address;
        logic              mirror_mode;
    } map_res_t;

endpackage

>>> hdl/cbm_sram.sv
// ----------------------------------------------------------------------------
// cbm_sram: save RAM with registered read and a clearing sweep after reset
// One write port and one read port; entries at or beyond the depth read as
// zero and ignore writes. After reset every entry is written with zero.
// ----------------------------------------------------------------------------
module cbm_sram
    import cbm_pkg::*;
#(
    parameter int SAVE_RAM_DEPTH = SAVE_RAM_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  ram_cmd_t          cmd,
    output logic [DATA_W-1:0] rdata,
    output logic              busy
);

    localparam int RAM_AW = $clog2(SAVE_RAM_DEPTH);

    logic [DATA_W-1:0] mem [SAVE_RAM_DEPTH];
    logic [RAM_AW-1:0] clr_idx_reg;
    logic              busy_reg;
    logic [DATA_W-1:0] rdata_reg;
    logic              in_range;
    logic [RAM_AW-1:0] mem_idx;

    assign in_range = (32'(cmd.idx) < SAVE_RAM_DEPTH);
    assign mem_idx  = RAM_AW'(cmd.idx);

    // Clearing sweep, one entry per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg <= '0;
            busy_reg    <= 1'b1;
        end else if (busy_reg) begin
            clr_idx_reg <= clr_idx_reg + RAM_AW'(1);
            if (clr_idx_reg == RAM_AW'(SAVE_RAM_DEPTH - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Write port: the sweep owns it while busy.
    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            mem[clr_idx_reg] <= '0;
        end else if (cmd.wr && in_range) begin
            mem[mem_idx] <= cmd.wdata;
        end
    end

    // Registered read port; holds when no read is issued.
    always_ff @(posedge aclk) begin
        if (cmd.rd) begin
            rdata_reg <= in_range ? mem[mem_idx] : '0;
        end
    end

    assign rdata = rdata_reg;
    assign busy  = busy_reg;

endmodule

>>> hdl/cbm_map.sv
// ----------------------------------------------------------------------------
// cbm_map: mapper registers, request decode and address translation
// Holds the bank, control and key registers, decides save-RAM gating and
// forms the program and pattern addresses for each accepted request.
// ----------------------------------------------------------------------------
module cbm_map
    import cbm_pkg::*;
#(
    parameter int PRG_BANK_BITS = PRG_BANK_BITS_DEF,
    parameter int CHR_BANK_BITS = CHR_BANK_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              accept,
    input  logic [OP_W-1:0]   op,
    input  logic [ADDR_W-1:0] address,
    input  logic [DATA_W-1:0] write_data,
    output ram_cmd_t          cmd,
    output map_res_t          res
);

    logic [PRG_BANK_BITS-1:0] prg_bank_reg [3];
    logic [CHR_BANK_BITS-1:0] chr_bank_reg [6];
    logic [DATA_W-1:0]        ram_key_reg  [3];
    logic                     mirror_reg;
    logic                     swap_reg;

    logic                     is_rd, is_wr, is_cpu, in_window;
    logic                     reg0, reg1, reg2, in_sram, open;
    logic                     reg_wr;
    logic [DATA_W-1:0]        prg_val;
    logic [PRG_BANK_BITS-1:0] prg_sel_bank;
    logic [PRG_W-1:0]         prg_map;
    logic [2:0]               slot;
    logic [2:0]               chr_idx;
    logic [CHR_BANK_BITS-1:0] chr_sel_bank;
    logic [CHR_W-1:0]         chr_map;

    // Request classification and save-RAM gating.
    always_comb begin
        is_rd     = (op == OP_CPU_READ);
        is_wr     = (op == OP_CPU_WRITE);
        is_cpu    = is_rd || is_wr;
        in_window = (address[15:13] == 3'b011);
        reg0      = (address[15:11] == 5'b01100);
        reg1      = (address[15:11] == 5'b01101);
        reg2      = (address[15:10] == 6'b011100);
        in_sram   = reg0 || reg1 || reg2;
        open      = (reg0 && ram_key_reg[0] == KEY_REGION0)
                 || (reg1 && ram_key_reg[1] == KEY_REGION1)
                 || (reg2 && ram_key_reg[2] == KEY_REGION2);
        reg_wr    = accept && is_wr && in_window && !in_sram;
    end

    // Save-RAM command.
    assign cmd.rd    = accept && is_rd && in_window && open;
    assign cmd.wr    = accept && is_wr && in_window && open;
    assign cmd.idx   = address[RAM_IDX_W-1:0];
    assign cmd.wdata = write_data;

    // Program mapping: the top 8 KiB window uses the highest bank.
    always_comb begin
        prg_sel_bank = (address[14:13] == 2'b11) ? '1 : prg_bank_reg[address[14:13]];
        prg_map      = PRG_W'({prg_sel_bank, address[12:0]});
    end

    // Pattern mapping: two 2 KiB banks then four 1 KiB banks, halves swapped when the swap bit is set.
    always_comb begin
        slot         = address[12:10] ^ {swap_reg, 2'b00};
        chr_idx      = slot[2] ? (3'd2 + {1'b0, slot[1:0]}) : {2'b00, slot[1]};
        chr_sel_bank = chr_bank_reg[chr_idx];
        if (slot[2]) begin
            chr_map = CHR_W'({chr_sel_bank, address[9:0]});
        end else begin
            chr_map = CHR_W'({chr_sel_bank >> 1, address[10:0]});
        end
    end

    // Result fields known at acceptance.
    always_comb begin
        res.from_ram    = is_rd && in_window && open;
        res.bus_byte    = (is_rd && in_window && !open) ? address[15:8] : '0;
        res.prg_address = (is_cpu && address[15]) ? prg_map : '0;
        res.chr_address = (op == OP_PPU_FETCH) ? chr_map : '0;
        res.mirror_mode = (reg_wr && address == REG_CTRL) ? write_data[0] : mirror_reg;
    end

    assign prg_val = write_data >> 2;

    // Register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                prg_bank_reg[i] <= '0;
                ram_key_reg[i]  <= '0;
            end
            for (int i = 0; i < 6; i++) begin
                chr_bank_reg[i] <= '0;
            end
            mirror_reg <= 1'b0;
            swap_reg   <= 1'b0;
        end else if (reg_wr) begin
            unique case (address)
                REG_CHR0: chr_bank_reg[0] <= write_data[CHR_BANK_BITS-1:0];
                REG_CHR1: chr_bank_reg[1] <= write_data[CHR_BANK_BITS-1:0];
                REG_CHR2: chr_bank_reg[2] <= write_data[CHR_BANK_BITS-1:0];
                REG_CHR3: chr_bank_reg[3] <= write_data[CHR_BANK_BITS-1:0];
                REG_CHR4: chr_bank_reg[4] <= write_data[CHR_BANK_BITS-1:0];
                REG_CHR5: chr_bank_reg[5] <= write_data[CHR_BANK_BITS-1:0];
                REG_CTRL: begin
                    mirror_reg <= write_data[0];
                    swap_reg   <= write_data[1];
                end
                REG_KEY0: ram_key_reg[0] <= write_data;
                REG_KEY1: ram_key_reg[1] <= write_data;
                REG_KEY2: ram_key_reg[2] <= write_data;
                REG_PRG0: prg_bank_reg[0] <= prg_val[PRG_BANK_BITS-1:0];
                REG_PRG1: prg_bank_reg[1] <= prg_val[PRG_BANK_BITS-1:0];
                REG_PRG2: prg_bank_reg[2] <= prg_val[PRG_BANK_BITS-1:0];
                default: ;
            endcase
        end
    end

endmodule

>>> hdl/cartridge_bank_mapper_sram_gate_unit.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper_sram_gate_unit: bank mapper with gated save RAM
// Translates CPU and PPU requests, loads mapper registers and serves the
// key-gated save RAM.
//
//   Channel | Ports       | Contents (lowest bit first)
//   --------+-------------+-------------------------------------------------
//   input   | s_t*        | tuser: op; tdata: address, write_data
//   result  | m_t*        | tdata: read_data, prg_address, chr_address,
//           |             |        mirror_mode
//
// One request per cycle is accepted while the save RAM is not being
// cleared and stage one is free or can advance; results pass through
// stage one, for the save-RAM read, and the output register. After reset
// the save RAM is cleared one entry per cycle, with s_tready low meanwhile.
// A stalled result stage holds its data; input flows until both are full.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper_sram_gate_unit
    import cbm_pkg::*;
#(
    parameter int SAVE_RAM_DEPTH = SAVE_RAM_DEPTH_DEF,
    parameter int PRG_BANK_BITS  = PRG_BANK_BITS_DEF,
    parameter int CHR_BANK_BITS  = CHR_BANK_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // address[15:0], write_data[23:16]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // read_data[7:0], prg_address[26:8],
                                   // chr_address[44:27], mirror_mode[45]
);

    ram_cmd_t          cmd;
    map_res_t          res;
    logic [DATA_W-1:0] ram_rdata;
    logic              ram_busy;
    logic              accept;
    logic              p1_advance;

    logic              p1_valid_reg;
    map_res_t          p1_res_reg;
    logic              out_valid_reg;
    logic [47:0]       out_data_reg;

    assign p1_advance = !out_valid_reg || m_tready;
    assign s_tready   = !ram_busy && (!p1_valid_reg || p1_advance);
    assign accept     = s_tvalid && s_tready;

    // Register file, gating and address translation.
    cbm_map #(
        .PRG_BANK_BITS (PRG_BANK_BITS),
        .CHR_BANK_BITS (CHR_BANK_BITS)
    ) u_map (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .op         (s_tuser),
        .address    (s_tdata[15:0]),
        .write_data (s_tdata[23:16]),
        .cmd        (cmd),
        .res        (res)
    );

    // Save RAM.
    cbm_sram #(
        .SAVE_RAM_DEPTH (SAVE_RAM_DEPTH)
    ) u_sram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .rdata   (ram_rdata),
        .busy    (ram_busy)
    );

    // Stage one: waits for the save-RAM read data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (accept) begin
            p1_valid_reg <= 1'b1;
        end else if (p1_advance) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_res_reg <= res;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (p1_advance) begin
            out_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_advance && p1_valid_reg) begin
            out_data_reg <= {2'b00,
                             p1_res_reg.mirror_mode,
                             p1_res_reg.chr_address,
                             p1_res_reg.prg_address,
                             p1_res_reg.from_ram ? ram_rdata : p1_res_reg.bus_byte};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // No request is taken while the save RAM is being cleared.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |-> !ram_busy)
        else $error("request accepted during save RAM clear");

    // Only CPU writes reach the save-RAM write port.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr |-> (s_tuser == OP_CPU_WRITE))
        else $error("save RAM write from a non-write request");

    // A stalled stage-one request is kept, never dropped.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && !p1_advance) |=> p1_valid_reg)
        else $error("stage one request lost during stall");

    // A save-RAM read and write never come from the same request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.rd && cmd.wr))
        else $error("save RAM read and write issued together");
`endif

endmodule
